FILE: src/aes_pkg.sv
// package for the aes-128 cbc encryption block
// types, state enum, s-box and round helper functions; no dependencies
`default_nettype none
package aes_pkg;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
        logic        start_of_message;
    } in_item_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } out_item_t;

    typedef enum logic [1:0] {
        CFG_KEY_HIGH = 2'd0,
        CFG_KEY_LOW  = 2'd1,
        CFG_IV_HIGH  = 2'd2,
        CFG_IV_LOW   = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_ROUND,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic       capture;   // take input item
        logic       key_init;  // load key registers and iv into chain
        logic       key_step;  // one key expansion step
        logic       load;      // xor with chain and round key 0
        logic       round;     // one cipher round
        logic       last;      // final round, no mixcolumns
        logic       emit;      // copy finished block to the output register
        logic [3:0] rnd;       // round number for key store access and rcon
    } dp_cmd_t;

    localparam logic [7:0] RCON [0:10] = '{
        8'h8d, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte i of the state is bits 127-8i downto 120-8i
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (r + 4 * c) -: 8] = SBOX[s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]];
            end
        end
        sub_shift = t;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            t[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        mix_cols = t;
    endfunction

endpackage
`default_nettype wire

FILE: src/aes_ctrl.sv
// sequencer for key expansion and the ten cipher rounds
// depends on aes_pkg
`default_nettype none
module aes_ctrl
    import aes_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire logic    in_start,
    output logic         out_valid,
    input  wire logic    out_stall,
    output dp_cmd_t      cmd
);

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       ready_reg, ready_next;   // keys expanded since reset
    logic       out_valid_reg, out_valid_next;

    logic       accept;
    logic       out_free;
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ready_next     = ready_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cnt_next = 4'd1;
                    if (in_start || !ready_reg) begin
                        state_next = ST_EXPAND;
                        ready_next = 1'b1;
                    end else begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_EXPAND: begin
                if (cnt_reg == 4'd10) begin
                    state_next = ST_LOAD;
                end
                cnt_next = (cnt_reg == 4'd10) ? 4'd1 : cnt_reg + 4'd1;
            end
            ST_LOAD: begin
                state_next = ST_ROUND;
                cnt_next   = 4'd1;
            end
            ST_ROUND: begin
                if (cnt_reg == 4'd10) begin
                    state_next = ST_OUT;
                end
                cnt_next = cnt_reg + 4'd1;
            end
            ST_OUT: begin
                // wait here only while the output register still holds an item that the receiver stalls
                if (out_free) begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_stall      = (state_reg != ST_IDLE);
        out_valid     = out_valid_reg;
        cmd           = '0;
        cmd.capture   = (state_reg == ST_IDLE) && accept;
        cmd.key_init  = cmd.capture && (in_start || !ready_reg);
        cmd.key_step  = (state_reg == ST_EXPAND);
        cmd.load      = (state_reg == ST_LOAD);
        cmd.round     = (state_reg == ST_ROUND);
        cmd.last      = (state_reg == ST_ROUND) && (cnt_reg == 4'd10);
        cmd.emit      = (state_reg == ST_OUT) && out_free;
        cmd.rnd       = (state_reg == ST_LOAD) ? 4'd0 : cnt_reg;
    end

endmodule
`default_nettype wire

FILE: src/aes_dp.sv
// datapath: config registers, key expansion, round key store, round unit
// depends on aes_pkg
`default_nettype none
module aes_dp
    import aes_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_write,
    input  wire logic [1:0] cfg_idx,
    input  wire logic [63:0] cfg_data,
    input  in_item_t       in_item,
    input  dp_cmd_t        cmd,
    output out_item_t      out_item
);

    logic [63:0]  key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic [127:0] chain_reg, chain_next;
    logic [127:0] plain_reg;
    logic [127:0] state_reg, state_next;
    logic [127:0] wkey_reg, wkey_next;   // running key in expansion
    logic [127:0] rk_store [0:10];
    logic [127:0] out_reg;
    logic [31:0]  t;
    logic [127:0] sb;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
            chain_reg    <= '0;
        end else begin
            if (cfg_write) begin
                unique case (cfg_index_t'(cfg_idx))
                    CFG_KEY_HIGH: key_high_reg <= cfg_data;
                    CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                    CFG_IV_HIGH:  iv_high_reg  <= cfg_data;
                    CFG_IV_LOW:   iv_low_reg   <= cfg_data;
                    default: ;
                endcase
            end
            chain_reg <= chain_next;
        end
    end

    always_comb begin
        chain_next = chain_reg;
        if (cmd.key_init) begin
            chain_next = {iv_high_reg, iv_low_reg};
        end else if (cmd.last) begin
            chain_next = state_next;
        end
    end

    // key schedule, one round key per cycle
    always_comb begin
        t = sub_word({wkey_reg[23:0], wkey_reg[31:24]}) ^ {RCON[cmd.rnd], 24'h0};
        wkey_next[127:96] = wkey_reg[127:96] ^ t;
        wkey_next[95:64]  = wkey_reg[95:64] ^ wkey_next[127:96];
        wkey_next[63:32]  = wkey_reg[63:32] ^ wkey_next[95:64];
        wkey_next[31:0]   = wkey_reg[31:0] ^ wkey_next[63:32];
    end

    always_ff @(posedge clk) begin
        if (cmd.key_init) begin
            wkey_reg    <= {key_high_reg, key_low_reg};
            rk_store[0] <= {key_high_reg, key_low_reg};
        end else if (cmd.key_step) begin
            wkey_reg           <= wkey_next;
            rk_store[cmd.rnd]  <= wkey_next;
        end
    end

    // key store read is registered and runs ahead: read address is the next round
    // round key 0 is reread during expansion, its write lands with the capture
    logic [3:0] rd_addr;
    logic [127:0] rk_q;
    assign rd_addr = (cmd.capture || cmd.key_step) ? 4'd0
                   : (cmd.load ? 4'd1 : cmd.rnd + 4'd1);
    always_ff @(posedge clk) begin
        rk_q <= rk_store[(rd_addr > 4'd10) ? 4'd10 : rd_addr];
    end

    always_comb begin
        sb = sub_shift(state_reg);
        state_next = state_reg;
        if (cmd.load) begin
            state_next = plain_reg ^ chain_reg ^ rk_q;
        end else if (cmd.round) begin
            state_next = (cmd.last ? sb : mix_cols(sb)) ^ rk_q;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            plain_reg <= {in_item.plain_high, in_item.plain_low};
        end
        state_reg <= state_next;
        if (cmd.emit) begin
            out_reg <= state_reg;
        end
    end

    assign out_item.cipher_high = out_reg[127:64];
    assign out_item.cipher_low  = out_reg[63:0];

endmodule
`default_nettype wire

FILE: src/aes128_cbc_encrypt_top.sv
// top level of the aes-128 cbc encryption block
// channel    dir  handshake         payload
// in         in   valid / stall     in_item_t
// out        out  valid / stall     out_item_t
// cfg        in   valid / ready     index, data
// after acceptance an item goes through load, ten rounds one a cycle through
// the single round unit and a copy into the output register; the next item is
// taken only after the previous one is copied to the output register. a start of
// message or the first item after reset adds key expansion. reset clears control
// and config; a finished block waits on a full, stalled output, holding the input.
// depends on aes_pkg, aes_ctrl, aes_dp
`default_nettype none
module aes128_cbc_encrypt_top
    import aes_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  in_item_t       in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [63:0] cfg_data
);

    dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    aes_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_start  (in_data.start_of_message),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    aes_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_idx   (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_data),
        .cmd       (cmd),
        .out_item  (out_data)
    );

    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_stall, out_valid})) else $error("handshake output unknown");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed under stall");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall) else $error("accepted item not worked on");

endmodule
`default_nettype wire

FILE: verif/aes_cbc_checker.sv
// checker for the aes-128 cbc encryption block: watches the config, input and output
// channels, predicts each ciphertext item and compares it field by field
// depends on aes_pkg for the item and register index types
`default_nettype none
module aes_cbc_checker
    import aes_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  in_item_t         in_data,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  out_item_t        out_data,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    output int               fail_count,
    output int               cipher_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]   sub_tab [0:255];
    logic [63:0]  key_hi, key_lo, iv_hi, iv_lo;
    logic [127:0] chain;
    logic [127:0] rkeys [0:10];
    logic         keys_valid;
    out_item_t    cipher_q [$];

    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = dbl(a);
        end
        return p;
    endfunction

    // inverse as x^254, then the affine map
    function automatic logic [7:0] sub_byte_calc(input logic [7:0] x);
        logic [7:0] r, base;
        r = 8'h01;
        base = x;
        for (int e = 254; e != 0; e >>= 1)
        begin
            if (e & 1)
                r = gmul(r, base);
            base = gmul(base, base);
        end
        return r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]} ^ {r[3:0], r[7:4]}
            ^ 8'h63;
    endfunction

    initial
    begin
        for (int i = 0; i < 256; i++)
            sub_tab[i] = sub_byte_calc(8'(i));
    end

    function automatic void expand_round_keys(input logic [127:0] k);
        logic [31:0] w [0:43];
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        for (int i = 0; i < 4; i++)
            w[i] = k[127 - 32 * i -: 32];
        for (int i = 4; i < 44; i++)
        begin
            t = w[i - 1];
            if (i % 4 == 0)
            begin
                t = {sub_tab[t[23:16]], sub_tab[t[15:8]], sub_tab[t[7:0]], sub_tab[t[31:24]]}
                    ^ {rc, 24'h0};
                rc = dbl(rc);
            end
            w[i] = w[i - 4] ^ t;
        end
        for (int r = 0; r < 11; r++)
            rkeys[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
    endfunction

    // byte i of the state sits at bits 127-8i downto 120-8i
    function automatic logic [127:0] encrypt_block(input logic [127:0] blk);
        logic [127:0] s, t;
        logic [7:0]   a0, a1, a2, a3;
        s = blk ^ rkeys[0];
        for (int rnd = 1; rnd <= 10; rnd++)
        begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    t[127 - 8 * (r + 4 * c) -: 8] = sub_tab[s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]];
            s = t;
            if (rnd != 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[127 - 32 * c -: 8];
                    a1 = t[119 - 32 * c -: 8];
                    a2 = t[111 - 32 * c -: 8];
                    a3 = t[103 - 32 * c -: 8];
                    s[127 - 32 * c -: 8] = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
                    s[119 - 32 * c -: 8] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
                    s[111 - 32 * c -: 8] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
                    s[103 - 32 * c -: 8] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
                end
            end
            s ^= rkeys[rnd];
        end
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        logic [127:0] ct;
        if (!rst_n)
        begin
            key_hi = '0;
            key_lo = '0;
            iv_hi = '0;
            iv_lo = '0;
            chain = '0;
            keys_valid = 1'b0;
            cipher_q.delete();
            fail_count = 0;
            cipher_pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_KEY_HIGH: key_hi = cfg_data;
                    CFG_KEY_LOW:  key_lo = cfg_data;
                    CFG_IV_HIGH:  iv_hi = cfg_data;
                    CFG_IV_LOW:   iv_lo = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                // the first item after reset restarts the message as well
                if (in_data.start_of_message || !keys_valid)
                begin
                    chain = {iv_hi, iv_lo};
                    expand_round_keys({key_hi, key_lo});
                    keys_valid = 1'b1;
                end
                ct = encrypt_block({in_data.plain_high, in_data.plain_low} ^ chain);
                chain = ct;
                cipher_q = {cipher_q, out_item_t'(ct)};
            end
            if (out_valid && !out_stall)
            begin
                if (cipher_q.size() == 0)
                begin
                    $error("ciphertext item with none expected: %h", out_data);
                    fail_count++;
                end
                else
                begin
                    want = cipher_q.pop_front();
                    if (out_data.cipher_high !== want.cipher_high)
                    begin
                        $error("cipher_high expected %h actual %h", want.cipher_high,
                            out_data.cipher_high);
                        fail_count++;
                    end
                    if (out_data.cipher_low !== want.cipher_low)
                    begin
                        $error("cipher_low expected %h actual %h", want.cipher_low,
                            out_data.cipher_low);
                        fail_count++;
                    end
                end
            end
            cipher_pending = cipher_q.size();
        end
    end
endmodule
`default_nettype wire

FILE: verif/testbench.sv
// top of the aes-128 cbc encryption testbench: clock, reset, register writes and
// plaintext stimulus with random gaps and stalls; verdict from aes_cbc_checker
// depends on aes_pkg, aes128_cbc_encrypt_top and aes_cbc_checker
`default_nettype none
module testbench
    import aes_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    int          fail_count;
    int          cipher_pending;
    logic        steady;
    int          cycles;

    aes128_cbc_encrypt_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    aes_cbc_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .cipher_pending (cipher_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver stalls at random except during the steady stretch
    always @(negedge clk)
        out_stall <= !steady && ($urandom_range(99) < 30);

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 600000)
            begin
                $display("FAIL aes128_cbc_encrypt_top");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    // stall only moves at rising edges, so its level at the falling edge holds
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input logic som);
        while (!steady && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{plain_high: hi, plain_low: lo, start_of_message: som};
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (cipher_pending != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_regs(input logic [63:0] kh, input logic [63:0] kl,
                            input logic [63:0] ih, input logic [63:0] il);
        write_reg(CFG_KEY_HIGH, kh);
        write_reg(CFG_KEY_LOW, kl);
        write_reg(CFG_IV_HIGH, ih);
        write_reg(CFG_IV_LOW, il);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int sent;
        int msg_len;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        steady = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // first item after reset without the start flag, all-zero key and iv
        send_block('0, '0, 1'b0);
        send_block('1, '1, 1'b0);
        send_block('0, '1, 1'b0);
        send_block('1, '0, 1'b1);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
        drain();

        // textbook key with zero iv
        set_regs(64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
        drain();

        // all-ones registers
        set_regs('1, '1, '1, '1);
        send_block('0, '0, 1'b1);
        send_block('1, '1, 1'b0);
        send_block(rand64(), rand64(), 1'b1);
        drain();

        // registers changed mid message only count from the next start
        set_regs(rand64(), rand64(), rand64(), rand64());
        send_block(rand64(), rand64(), 1'b0);
        send_block(rand64(), rand64(), 1'b0);
        send_block('0, '0, 1'b1);
        send_block('1, '1, 1'b1);
        drain();

        sent = 0;
        while (sent < 700)
        begin
            steady = (sent >= 300 && sent < 400);
            if ($urandom_range(9) == 0)
            begin
                drain();
                case ($urandom_range(3))
                    0: set_regs('0, '0, '0, '0);
                    1: set_regs('1, '1, '1, '1);
                    default: set_regs(rand64(), rand64(), rand64(), rand64());
                endcase
            end
            msg_len = $urandom_range(1, 12);
            for (int i = 0; i < msg_len; i++)
            begin
                // mostly clean messages, now and then a stray restart or missing start
                send_block(rand64(), rand64(),
                    (i == 0) ? ($urandom_range(19) != 0) : ($urandom_range(29) == 0));
                sent++;
            end
        end
        steady = 1'b0;
        drain();

        if (fail_count == 0 && cipher_pending == 0)
            $display("PASS aes128_cbc_encrypt_top");
        else
            $display("FAIL aes128_cbc_encrypt_top");
        $finish;
    end
endmodule
`default_nettype wire

FILE: aes128_cbc_encrypt_top.f
src/aes_pkg.sv
src/aes_ctrl.sv
src/aes_dp.sv
src/aes128_cbc_encrypt_top.sv
verif/aes_cbc_checker.sv
verif/testbench.sv
